// ===== design/bmp_pkg.sv =====
package bmp_pkg;

	localparam int CNT_W = 11;
	localparam int RES_W = 30;
	localparam int K_W   = 10;
	localparam int BIT_W = 5;
	localparam int OP_W  = 31;
	localparam int PROD_W = 2 * OP_W;

	localparam logic [RES_W-1:0] PRIME     = 30'd1000000007;
	localparam logic [RES_W-1:0] EXP_INV   = 30'd1000000005;
	localparam logic [OP_W-1:0]  BAR_MU    = 31'd1152921496;
	localparam logic [CNT_W-1:0] MAX_SIDE  = 11'd1024;
	localparam logic [BIT_W-1:0] LAST_BIT  = BIT_W'(RES_W - 1);

	typedef struct packed {
		logic             start;
		logic [RES_W-1:0] a;
		logic [RES_W-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic             done;
		logic [RES_W-1:0] r;
	} mm_rsp_t;

endpackage

// ===== design/bmp_mulmod.sv =====
module bmp_mulmod
	import bmp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);

	typedef enum logic [1:0] {
		M_IDLE,
		M_RED1,
		M_RED2,
		M_FIX
	} mstate_t;

	mstate_t           state_q;
	logic [PROD_W-1:0] prod_q;
	logic [31:0]       x_q;
	logic [RES_W-1:0]  res_q;
	logic              done_q;

	logic [OP_W-1:0]   mul_a;
	logic [OP_W-1:0]   mul_b;
	logic [PROD_W-1:0] mul_p;
	logic [31:0]       r0;
	logic [31:0]       r1;
	logic [31:0]       r2;

	// one multiplier serves the product and both Barrett steps
	always_comb begin
		unique case (state_q)
			M_IDLE: begin
				mul_a = {1'b0, req.a};
				mul_b = {1'b0, req.b};
			end
			M_RED1: begin
				mul_a = prod_q[59:29];
				mul_b = BAR_MU;
			end
			M_RED2: begin
				mul_a = prod_q[61:31];
				mul_b = {1'b0, PRIME};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign r0 = x_q - prod_q[31:0];
	assign r1 = (r0 >= 32'(PRIME)) ? r0 - 32'(PRIME) : r0;
	assign r2 = (r1 >= 32'(PRIME)) ? r1 - 32'(PRIME) : r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			prod_q  <= '0;
			x_q     <= '0;
			res_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						prod_q  <= mul_p;
						state_q <= M_RED1;
					end
				end
				M_RED1: begin
					x_q     <= prod_q[31:0];
					prod_q  <= mul_p;
					state_q <= M_RED2;
				end
				M_RED2: begin
					prod_q  <= mul_p;
					state_q <= M_FIX;
				end
				M_FIX: begin
					res_q   <= r2[RES_W-1:0];
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.r    = res_q;

endmodule

// ===== design/bmp_seq.sv =====
module bmp_seq
	import bmp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CNT_W-1:0] set_size,
	input  logic [CNT_W-1:0] pick_count,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [RES_W-1:0] residue,
	output logic             out_of_range,
	output mm_req_t          mm_req,
	input  mm_rsp_t          mm_rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_NUM,
		S_DEN,
		S_PMUL,
		S_PSQR,
		S_FINAL,
		S_DONE
	} state_t;

	state_t           state_q;
	logic             busy_q;
	logic [CNT_W-1:0] hi_q;
	logic [K_W-1:0]   k_q;
	logic [K_W-1:0]   i_q;
	logic [RES_W-1:0] num_q;
	logic [RES_W-1:0] den_q;
	logic [RES_W-1:0] base_q;
	logic [RES_W-1:0] acc_q;
	logic [BIT_W-1:0] bit_q;
	logic             oor_q;
	logic             out_valid_q;
	logic [RES_W-1:0] residue_q;
	logic             out_of_range_q;

	logic             oor;
	logic [CNT_W-1:0] hi;
	logic [CNT_W-1:0] lo;
	logic [CNT_W-1:0] diff;
	logic [CNT_W-1:0] k;
	logic [K_W-1:0]   i_next;

	assign in_ready = (state_q == S_IDLE);

	assign oor  = (set_size > MAX_SIDE) || (pick_count > MAX_SIDE);
	assign hi   = (set_size > pick_count) ? set_size : pick_count;
	assign lo   = (set_size > pick_count) ? pick_count : set_size;
	assign diff = hi - lo;
	assign k    = (diff < lo) ? diff : lo;

	assign i_next = i_q + K_W'(1);

	always_comb begin
		mm_req.start = 1'b0;
		mm_req.a     = num_q;
		mm_req.b     = acc_q;
		unique case (state_q)
			S_NUM: begin
				mm_req.start = !busy_q;
				mm_req.a     = num_q;
				mm_req.b     = RES_W'(hi_q - CNT_W'(i_q));
			end
			S_DEN: begin
				mm_req.start = !busy_q;
				mm_req.a     = den_q;
				mm_req.b     = RES_W'(i_next);
			end
			S_PMUL: begin
				mm_req.start = !busy_q && EXP_INV[bit_q];
				mm_req.a     = acc_q;
				mm_req.b     = base_q;
			end
			S_PSQR: begin
				mm_req.start = !busy_q && (bit_q != LAST_BIT);
				mm_req.a     = base_q;
				mm_req.b     = base_q;
			end
			S_FINAL: begin
				mm_req.start = !busy_q;
				mm_req.a     = num_q;
				mm_req.b     = acc_q;
			end
			default: begin
				mm_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			busy_q         <= 1'b0;
			hi_q           <= '0;
			k_q            <= '0;
			i_q            <= '0;
			num_q          <= '0;
			den_q          <= '0;
			base_q         <= '0;
			acc_q          <= '0;
			bit_q          <= '0;
			oor_q          <= 1'b0;
			out_valid_q    <= 1'b0;
			residue_q      <= '0;
			out_of_range_q <= 1'b0;
		end else begin
			if (mm_req.start) begin
				busy_q <= 1'b1;
			end
			if (mm_rsp.done) begin
				busy_q <= 1'b0;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						hi_q  <= hi;
						k_q   <= k[K_W-1:0];
						i_q   <= '0;
						den_q <= RES_W'(1);
						acc_q <= RES_W'(1);
						bit_q <= '0;
						if (oor) begin
							num_q   <= '0;
							oor_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							num_q <= RES_W'(1);
							oor_q <= 1'b0;
							if (k == '0) begin
								state_q <= S_FINAL;
							end else begin
								state_q <= S_NUM;
							end
						end
					end
				end
				S_NUM: begin
					if (mm_rsp.done) begin
						num_q   <= mm_rsp.r;
						state_q <= S_DEN;
					end
				end
				S_DEN: begin
					if (mm_rsp.done) begin
						den_q <= mm_rsp.r;
						i_q   <= i_next;
						if (i_next == k_q) begin
							base_q  <= mm_rsp.r;
							state_q <= S_PMUL;
						end else begin
							state_q <= S_NUM;
						end
					end
				end
				S_PMUL: begin
					if (!EXP_INV[bit_q]) begin
						state_q <= S_PSQR;
					end else if (mm_rsp.done) begin
						acc_q   <= mm_rsp.r;
						state_q <= S_PSQR;
					end
				end
				S_PSQR: begin
					if (bit_q == LAST_BIT) begin
						state_q <= S_FINAL;
					end else if (mm_rsp.done) begin
						base_q  <= mm_rsp.r;
						bit_q   <= bit_q + BIT_W'(1);
						state_q <= S_PMUL;
					end
				end
				S_FINAL: begin
					if (mm_rsp.done) begin
						num_q   <= mm_rsp.r;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						residue_q      <= num_q;
						out_of_range_q <= oor_q;
						out_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign residue      = residue_q;
	assign out_of_range = out_of_range_q;

endmodule

// ===== design/binomial_mod_prime.sv =====
// The modular products run one after another on the shared Barrett multiplier. The result
//   is presented after k = min(lo, hi-lo) numerator and denominator steps, the inverse and
//   a final product; with k of 0 only the final product, and none for an out-of-range item.
// Throughput: one item at a time; in_ready is high only when idle, and returns in the same
//   cycle that the result is presented. The output register lets the next item start while
//   a result waits. Asynchronous active-low reset clears all.
module binomial_mod_prime
	import bmp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CNT_W-1:0] set_size,
	input  logic [CNT_W-1:0] pick_count,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [RES_W-1:0] residue,
	output logic             out_of_range
);

	mm_req_t mm_req;
	mm_rsp_t mm_rsp;

	bmp_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.set_size     (set_size),
		.pick_count   (pick_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.residue      (residue),
		.out_of_range (out_of_range),
		.mm_req       (mm_req),
		.mm_rsp       (mm_rsp)
	);

	bmp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

`ifndef SYNTH
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (residue < PRIME))
		else $error("residue not reduced");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_range) |-> (residue == '0))
		else $error("out-of-range item with non-zero residue");

	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		mm_req.start |=> !mm_req.start)
		else $error("multiplier started twice in a row");

	a_no_start_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> !mm_req.start)
		else $error("multiplier started while returning a product");
`endif

endmodule

// ===== dv/binomial_mod_prime_test.sv =====
`timescale 1ns / 1ps

module binomial_mod_prime_test;
	import bmp_pkg::*;

	localparam int LIMIT  = 6000000;
	localparam int SETTLE = 40;
	localparam longint unsigned MODULUS = longint'(PRIME);

	typedef struct packed {
		logic [RES_W-1:0] residue;
		logic             out_of_range;
	} binom_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [CNT_W-1:0] set_size;
	logic [CNT_W-1:0] pick_count;
	logic             out_valid;
	logic             out_ready;
	logic [RES_W-1:0] residue;
	logic             out_of_range;

	binom_t pending_binoms[$];
	int     errors;
	int     cycle_count;
	bit     idle_on;
	int     hold;

	binomial_mod_prime dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.set_size    (set_size),
		.pick_count  (pick_count),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.residue     (residue),
		.out_of_range(out_of_range)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint unsigned mul_residue(longint unsigned a, longint unsigned b);
		return (a * b) % MODULUS;
	endfunction

	function automatic longint unsigned invert_residue(longint unsigned v);
		longint unsigned acc;
		longint unsigned base;
		longint unsigned e;
		acc  = 1;
		base = v % MODULUS;
		e    = MODULUS - 2;
		while (e != 0) begin
			if (e[0])
				acc = mul_residue(acc, base);
			base = mul_residue(base, base);
			e    = e >> 1;
		end
		return acc;
	endfunction

	function automatic binom_t predict_binom(logic [CNT_W-1:0] x, logic [CNT_W-1:0] y);
		binom_t          res;
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned num;
		longint unsigned den;
		res = '0;
		if (x > MAX_SIDE || y > MAX_SIDE) begin
			res.out_of_range = 1'b1;
			return res;
		end
		hi = (x > y) ? 64'(x) : 64'(y);
		lo = (x > y) ? 64'(y) : 64'(x);
		if (hi - lo < lo)
			lo = hi - lo;
		num = 1;
		den = 1;
		for (longint unsigned i = 0; i < lo; i++) begin
			num = mul_residue(num, hi - i);
			den = mul_residue(den, i + 1);
		end
		res.residue = RES_W'(mul_residue(num, invert_residue(den)));
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		else if (r < 90)
			return $urandom_range(4, 12);
		return $urandom_range(40, 200);
	endfunction

	task automatic report(input string msg);
		$display("%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic send_item(input logic [CNT_W-1:0] x, input logic [CNT_W-1:0] y);
		int gap;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		set_size   = x;
		pick_count = y;
		in_valid   = 1'b1;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		pending_binoms.push_back(predict_binom(x, y));
		@(negedge clk);
	endtask

	task automatic random_pair(output logic [CNT_W-1:0] x, output logic [CNT_W-1:0] y);
		int unsigned hi;
		int unsigned k;
		int unsigned lo;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			x = CNT_W'($urandom_range(1025, 2047));
			y = CNT_W'($urandom_range(0, 2047));
		end else begin
			hi = $urandom_range(0, 1024);
			r  = $urandom_range(0, 99);
			if (r < 85)
				k = $urandom_range(0, 24);
			else if (r < 96)
				k = $urandom_range(0, 100);
			else
				k = $urandom_range(0, 512);
			if (k > hi)
				k = hi;
			lo = $urandom_range(0, 1) ? k : hi - k;
			x  = CNT_W'(hi);
			y  = CNT_W'(lo);
		end
		if ($urandom_range(0, 1)) begin
			{x, y} = {y, x};
		end
	endtask

	task automatic test_edges();
		idle_on = 1'b1;
		send_item(11'd0, 11'd0);
		send_item(11'd1, 11'd0);
		send_item(11'd0, 11'd1);
		send_item(11'd7, 11'd7);
		send_item(11'd1024, 11'd1024);
		send_item(11'd1024, 11'd0);
		send_item(11'd0, 11'd1024);
		send_item(11'd1024, 11'd1);
		send_item(11'd1, 11'd1024);
		send_item(11'd1024, 11'd1023);
		send_item(11'd10, 11'd3);
		send_item(11'd3, 11'd10);
		send_item(11'd1000, 11'd500);
		send_item(11'd1024, 11'd512);
		send_item(11'd512, 11'd1024);
	endtask

	task automatic test_out_of_range();
		idle_on = 1'b1;
		send_item(11'd1025, 11'd1);
		send_item(11'd1, 11'd1025);
		send_item(11'd2047, 11'd2047);
		send_item(11'd2047, 11'd0);
		send_item(11'd0, 11'd2047);
		send_item(11'd1025, 11'd1024);
	endtask

	task automatic test_back_to_back();
		logic [CNT_W-1:0] x;
		logic [CNT_W-1:0] y;
		idle_on = 1'b0;
		repeat (40) begin
			random_pair(x, y);
			send_item(x, y);
		end
	endtask

	task automatic test_random();
		logic [CNT_W-1:0] x;
		logic [CNT_W-1:0] y;
		idle_on = 1'b1;
		repeat (230) begin
			random_pair(x, y);
			send_item(x, y);
		end
	endtask

	// wait for pending results to drain, then report
	task automatic finish_run();
		in_valid = 1'b0;
		while (pending_binoms.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	endtask

	initial begin
		errors     = 0;
		idle_on    = 1'b1;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		set_size   = '0;
		pick_count = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_edges();
		test_out_of_range();
		test_back_to_back();
		test_random();
		finish_run();
	end

	initial begin
		out_ready = 1'b0;
		hold      = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else begin
				out_ready = 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		binom_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_binoms.size() == 0) begin
				report($sformatf("unexpected result residue=%0d out_of_range=%0b",
					residue, out_of_range));
			end else begin
				want = pending_binoms.pop_front();
				if (residue !== want.residue)
					report($sformatf("residue %0d, expected %0d", residue, want.residue));
				if (out_of_range !== want.out_of_range)
					report($sformatf("out_of_range %0b, expected %0b",
						out_of_range, want.out_of_range));
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
design/bmp_pkg.sv
design/bmp_mulmod.sv
design/bmp_seq.sv
design/binomial_mod_prime.sv
dv/binomial_mod_prime_test.sv
